// ===== design/spmv_pkg.sv =====
// Package for the CSR sparse matrix-vector multiply: constants, codes and beat types.
`default_nettype none
package spmv_pkg;

    localparam int VECTOR_LEN = 1024;
    localparam int VALUE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ADDR_BITS  = $clog2(VECTOR_LEN);
    localparam int SLOT_BITS  = 10;
    localparam int ROW_BITS   = 16;
    localparam int PROD_BITS  = 2 * VALUE_BITS;
    localparam int QUOT_BITS  = PROD_BITS - FRAC_BITS;

    typedef enum logic [1:0] {
        ACT_LOAD      = 2'd0,
        ACT_NONZERO   = 2'd1,
        ACT_EMPTY_ROW = 2'd2
    } t_action;

    typedef struct packed {
        t_action                       action;
        logic        [SLOT_BITS-1:0]   vector_slot;
        logic signed [VALUE_BITS-1:0]  vector_value;
        logic        [SLOT_BITS-1:0]   column;
        logic signed [VALUE_BITS-1:0]  nonzero_value;
        logic                          row_end;
    } t_in_item;

    typedef struct packed {
        logic        [ROW_BITS-1:0]    row_number;
        logic signed [VALUE_BITS-1:0]  row_sum;
        logic                          saturated;
    } t_out_item;

endpackage
`default_nettype wire

// ===== design/spmv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== design/csr_sparse_matrix_vector_multiply.sv =====
// CSR sparse matrix-vector multiply: top level with a four-stage multiply-accumulate pipeline.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one beat per item.
// Load beats write a dense vector entry into a 1024-entry RAM at the accept edge;
// nonzero beats read the entry at their column, multiply it by the nonzero value
// (signed Q16.16, truncated toward zero, clipped) and add it to a saturating row
// sum. A nonzero with row_end set, or an empty-row beat, closes the row and puts
// one beat on the output channel (o_out_valid / i_out_ready / o_out_data) with
// the row number, the sum and a flag telling whether any clip happened.
// A closing beat passes the decode, multiply and clip registers to the output;
// one item is taken every cycle while no row result is left waiting at the output.
// A load may be followed at once by a nonzero reading it.
// The pipeline advances stage by stage: when the output register holds an
// untaken result, only a closing beat at the accumulator waits, and the stages
// behind it fill before o_in_ready drops.
// Reset clears the pipeline, row counter, sum and clip flag at once; the vector
// RAM is not cleared and must be loaded before it is read.
`default_nettype none
module csr_sparse_matrix_vector_multiply
    import spmv_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    typedef struct packed {
        logic                         use_vec;
        logic signed [VALUE_BITS-1:0] nz_value;
        logic                         close;
    } t_s1;

    typedef struct packed {
        logic                 neg;
        logic [PROD_BITS-1:0] prod;
        logic                 close;
    } t_s2;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         clip;
        logic                         close;
    } t_s3;

    localparam logic [QUOT_BITS-1:0] POS_LIMIT = QUOT_BITS'({1'b0, {(VALUE_BITS-1){1'b1}}});
    localparam logic [QUOT_BITS-1:0] NEG_LIMIT = QUOT_BITS'({1'b1, {(VALUE_BITS-1){1'b0}}});

    logic                    r_s1_valid, r_s2_valid, r_s3_valid;
    t_s1                     r_s1, n_s1;
    t_s2                     r_s2, n_s2;
    t_s3                     r_s3, n_s3;
    logic [VALUE_BITS-1:0]   w_rd_data;
    logic signed [VALUE_BITS-1:0] r_sum, n_sum;
    logic                    r_clip, n_clip;
    logic [ROW_BITS-1:0]     r_row;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic w_accept, w_go3, w_s3_free, w_s2_free, w_s1_free;
    logic w_wr_en, w_rd_en, w_slot_ok, w_col_ok;

    // stage flow: each stage moves when the one ahead is free
    assign w_go3      = r_s3_valid && !(r_s3.close && r_out_valid && !i_out_ready);
    assign w_s3_free  = !r_s3_valid || w_go3;
    assign w_s2_free  = !r_s2_valid || w_s3_free;
    assign w_s1_free  = !r_s1_valid || w_s2_free;
    assign o_in_ready = w_s1_free;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_slot_ok = 32'(i_in_data.vector_slot) < VECTOR_LEN;
    assign w_col_ok  = 32'(i_in_data.column) < VECTOR_LEN;
    assign w_wr_en   = w_accept && (i_in_data.action == ACT_LOAD) && w_slot_ok;
    assign w_rd_en   = w_accept && (i_in_data.action == ACT_NONZERO);

    spmv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (VECTOR_LEN)
    ) u_vec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (i_in_data.vector_slot[ADDR_BITS-1:0]),
        .i_wr_data (i_in_data.vector_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (i_in_data.column[ADDR_BITS-1:0]),
        .o_rd_data (w_rd_data)
    );

    // stage 1: decode the beat; loads and unused codes drop here
    always_comb begin
        n_s1 = '0;
        case (i_in_data.action)
            ACT_NONZERO: begin
                n_s1.use_vec  = w_col_ok;
                n_s1.nz_value = i_in_data.nonzero_value;
                n_s1.close    = i_in_data.row_end;
            end
            ACT_EMPTY_ROW: begin
                n_s1.close = 1'b1;
            end
            default: begin
                n_s1 = '0;
            end
        endcase
    end

    // stage 2: multiply magnitudes
    always_comb begin
        logic signed [VALUE_BITS-1:0] vec;
        logic [VALUE_BITS-1:0]        mag_a, mag_b;
        vec   = r_s1.use_vec ? signed'(w_rd_data) : '0;
        mag_a = r_s1.nz_value[VALUE_BITS-1] ? VALUE_BITS'(-r_s1.nz_value)
                                            : VALUE_BITS'(r_s1.nz_value);
        mag_b = vec[VALUE_BITS-1] ? VALUE_BITS'(-vec) : VALUE_BITS'(vec);
        n_s2.neg   = r_s1.nz_value[VALUE_BITS-1] ^ vec[VALUE_BITS-1];
        n_s2.prod  = {{VALUE_BITS{1'b0}}, mag_a} * {{VALUE_BITS{1'b0}}, mag_b};
        n_s2.close = r_s1.close;
    end

    // stage 3: drop fraction bits, clip to range, restore sign
    always_comb begin
        logic [QUOT_BITS-1:0]  quot, limit;
        logic [VALUE_BITS-1:0] mag;
        quot       = r_s2.prod[PROD_BITS-1:FRAC_BITS];
        limit      = r_s2.neg ? NEG_LIMIT : POS_LIMIT;
        n_s3.clip  = quot > limit;
        mag        = n_s3.clip ? limit[VALUE_BITS-1:0] : quot[VALUE_BITS-1:0];
        n_s3.value = r_s2.neg ? signed'(VALUE_BITS'(-mag)) : signed'(mag);
        n_s3.close = r_s2.close;
    end

    // stage 4: saturating accumulate
    always_comb begin
        logic signed [VALUE_BITS:0] wide;
        logic                       ovf;
        wide   = {r_sum[VALUE_BITS-1], r_sum} + {r_s3.value[VALUE_BITS-1], r_s3.value};
        ovf    = wide[VALUE_BITS] != wide[VALUE_BITS-1];
        n_clip = r_clip || r_s3.clip || ovf;
        if (!ovf) begin
            n_sum = wide[VALUE_BITS-1:0];
        end else if (wide[VALUE_BITS]) begin
            n_sum = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end else begin
            n_sum = {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
    end

    // advance pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= w_accept && ((i_in_data.action == ACT_NONZERO)
                                        || (i_in_data.action == ACT_EMPTY_ROW));
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_s3_free) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
        if (w_s2_free) begin
            r_s2 <= n_s2;
        end
        if (w_s3_free) begin
            r_s3 <= n_s3;
        end
    end

    // row state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_clip      <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go3 && r_s3.close) begin
                r_sum       <= '0;
                r_clip      <= 1'b0;
                r_row       <= r_row + 1'b1;
                r_out_valid <= 1'b1;
            end else begin
                if (w_go3) begin
                    r_sum  <= n_sum;
                    r_clip <= n_clip;
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // capture the closed row
    always_ff @(posedge i_clk) begin
        if (w_go3 && r_s3.close) begin
            r_out.row_number <= r_row;
            r_out.row_sum    <= n_sum;
            r_out.saturated  <= n_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the CSR sparse matrix-vector multiply.
`default_nettype none
module tb;
    import spmv_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int VECTOR_FILL  = 200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic signed [VALUE_BITS-1:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_BITS-1:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [VALUE_BITS-1:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [63:0] SUM_MAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SUM_MIN = -SUM_MAX - 64'sd1;
    // action code that the block must ignore
    localparam t_action ACT_UNUSED = t_action'(2'b11);

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    csr_sparse_matrix_vector_multiply dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mirror of the block: vector store, row accumulator, row counter, clip flag
    logic signed [VALUE_BITS-1:0] vec_mirror [VECTOR_LEN];
    logic signed [63:0]           acc_sum   = '0;
    logic [ROW_BITS-1:0]          row_count = '0;
    bit                           clip_flag = 1'b0;

    t_in_item  item_queue [$];
    t_out_item rows_due [$];
    t_out_item row_head;
    int        items_total = 0;
    int        items_taken = 0;
    int        fail_count  = 0;

    // stimulus bookkeeping: only loaded slots may be read
    bit slot_loaded [VECTOR_LEN];
    int loaded_slots [$];

    int in_gap = 0, in_quiet = 0, out_stall = 0, out_quiet = 0, idle_cycles = 0;

    function automatic void report_fail(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    // Q16.16 product: truncate magnitude toward zero, clip to range
    function automatic logic signed [63:0] q_product(
        input logic signed [VALUE_BITS-1:0] a,
        input logic signed [VALUE_BITS-1:0] b
    );
        logic signed [63:0] wa, wb;
        logic [63:0]        quot, limit;
        bit                 neg;
        wa    = a;
        wb    = b;
        neg   = (wa < 0) != (wb < 0);
        quot  = (64'(wa < 0 ? -wa : wa) * 64'(wb < 0 ? -wb : wb)) >> FRAC_BITS;
        limit = neg ? 64'(SUM_MAX) + 64'd1 : 64'(SUM_MAX);
        if (quot > limit) begin
            clip_flag = 1'b1;
            quot      = limit;
        end
        return neg ? -$signed(quot) : $signed(quot);
    endfunction

    function automatic void close_row();
        t_out_item row;
        row.row_number = row_count;
        row.row_sum    = acc_sum[VALUE_BITS-1:0];
        row.saturated  = clip_flag;
        rows_due.push_back(row);
        row_count++;
        acc_sum   = '0;
        clip_flag = 1'b0;
    endfunction

    // Advance the mirror by one accepted beat
    function automatic void spmv_predict(input t_in_item item);
        logic signed [63:0] total;
        case (item.action)
            ACT_LOAD: vec_mirror[item.vector_slot] = item.vector_value;
            ACT_NONZERO: begin
                total = acc_sum + q_product(item.nonzero_value, vec_mirror[item.column]);
                if (total > SUM_MAX) begin
                    total     = SUM_MAX;
                    clip_flag = 1'b1;
                end else if (total < SUM_MIN) begin
                    total     = SUM_MIN;
                    clip_flag = 1'b1;
                end
                acc_sum = total;
                if (item.row_end)
                    close_row();
            end
            ACT_EMPTY_ROW: close_row();
            default: ;
        endcase
    endfunction

    // Gap length: mostly none, some short, a few long; quiet spells have none
    function automatic int idle_len(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r == 0)
            quiet = $urandom_range(30, 120);
        if (r < 130)
            return 0;
        if (r < 175)
            return $urandom_range(1, 2);
        if (r < 195)
            return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    // Q16.16 value: extremes, small, medium or any
    function automatic logic signed [VALUE_BITS-1:0] rand_q();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 4))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return '0;
                3: return -Q_ONE;
                default: return 32'sd1;
            endcase
        end
        if (r < 50)
            return $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
        if (r < 85)
            return $signed($urandom_range(0, 32'h200_0000)) - 32'sh100_0000;
        return $urandom;
    endfunction

    // Fill unused fields at random so every bit toggles
    function automatic t_in_item rand_item(input t_action act);
        t_in_item item;
        item.action        = act;
        item.vector_slot   = SLOT_BITS'($urandom);
        item.vector_value  = VALUE_BITS'($urandom);
        item.column        = SLOT_BITS'($urandom);
        item.nonzero_value = VALUE_BITS'($urandom);
        item.row_end       = 1'($urandom);
        return item;
    endfunction

    function automatic void push_load(input int slot, input logic signed [VALUE_BITS-1:0] v);
        t_in_item item;
        item              = rand_item(ACT_LOAD);
        item.vector_slot  = SLOT_BITS'(slot);
        item.vector_value = v;
        item_queue.push_back(item);
        if (!slot_loaded[slot]) begin
            slot_loaded[slot] = 1'b1;
            loaded_slots.push_back(slot);
        end
    endfunction

    function automatic void push_nonzero(input int col, input logic signed [VALUE_BITS-1:0] v,
                                         input bit last);
        t_in_item item;
        item               = rand_item(ACT_NONZERO);
        item.column        = SLOT_BITS'(col);
        item.nonzero_value = v;
        item.row_end       = last;
        item_queue.push_back(item);
    endfunction

    function automatic void push_plain(input t_action act);
        item_queue.push_back(rand_item(act));
    endfunction

    // Build the stimulus, release reset, then wait for the last row
    initial begin
        int made, len, r, k;
        bit cut;

        // directed: extremes, truncation, clipping both ways, empty rows
        push_load(0, Q_MAX);
        push_load(VECTOR_LEN - 1, Q_MIN);
        push_load(5, Q_ONE);
        push_load(6, -Q_ONE);
        push_load(8, 32'sd3);
        push_plain(ACT_EMPTY_ROW);
        push_nonzero(5, 32'sh0002_8000, 1'b0);
        push_nonzero(6, Q_ONE, 1'b1);
        push_nonzero(0, Q_MAX, 1'b1);
        push_nonzero(VECTOR_LEN - 1, Q_MIN, 1'b1);
        push_nonzero(0, Q_MIN, 1'b0);
        push_plain(ACT_UNUSED);
        push_nonzero(6, Q_ONE, 1'b0);
        push_plain(ACT_EMPTY_ROW);
        push_nonzero(8, 32'shFFFF_8000, 1'b1);
        push_load(7, 32'sh0002_0000);
        push_nonzero(7, 32'sh0001_8000, 1'b1);
        push_nonzero(5, '0, 1'b0);
        push_nonzero(5, Q_MAX, 1'b1);
        push_nonzero(6, Q_MIN, 1'b1);
        push_nonzero(5, Q_MIN, 1'b1);

        // random: fill the vector, then rows with some noise and cut rows
        made = 0;
        while (made < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (made < VECTOR_FILL || r < 8) begin
                push_load($urandom_range(0, VECTOR_LEN - 1), rand_q());
                made++;
            end else if (r < 14) begin
                push_plain(ACT_EMPTY_ROW);
                made++;
            end else if (r < 17) begin
                push_plain(ACT_UNUSED);
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                cut = ($urandom_range(0, 19) == 0);
                for (k = 0; k < len; k++) begin
                    if (k > 0 && $urandom_range(0, 29) == 0)
                        push_plain(ACT_UNUSED);
                    push_nonzero(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)],
                                 rand_q(), (k == len - 1) && !cut);
                    made++;
                end
                if (cut)
                    push_plain(ACT_EMPTY_ROW);
            end
        end
        items_total = item_queue.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (items_taken < items_total || rows_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (rows_due.size() != 0)
            report_fail($sformatf("%0d row beats never arrived", rows_due.size()));
        if (fail_count == 0)
            $display("** csr_sparse_matrix_vector_multiply: PASSED **");
        else
            $display("** csr_sparse_matrix_vector_multiply: FAILED **");
        $finish;
    end

    // Driver: predict on each accepted beat, hold valid until taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                spmv_predict(in_data);
                items_taken++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (item_queue.size() != 0) begin
                    in_data  <= item_queue.pop_front();
                    in_valid <= 1'b1;
                    in_gap    = idle_len(in_quiet);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each row beat against the oldest prediction, stall at random
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (rows_due.size() == 0) begin
                    report_fail($sformatf("unexpected row beat: row %0d sum %h sat %b",
                                          out_data.row_number, out_data.row_sum,
                                          out_data.saturated));
                end else begin
                    row_head = rows_due.pop_front();
                    if (out_data.row_number !== row_head.row_number ||
                        out_data.row_sum !== row_head.row_sum ||
                        out_data.saturated !== row_head.saturated)
                        report_fail($sformatf(
                            {"row beat mismatch: expected row %0d sum %h sat %b, ",
                             "got row %0d sum %h sat %b"},
                            row_head.row_number, row_head.row_sum, row_head.saturated,
                            out_data.row_number, out_data.row_sum, out_data.saturated));
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                out_stall  = idle_len(out_quiet);
            end
        end
    end

    // Watchdog: drop the run if no beat moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** csr_sparse_matrix_vector_multiply: FAILED **");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire
